// ----- rtl/core/checkerboard_color_presence_downsampler_top_assert.svh -----
// Assertion macros for the downsampler
`ifndef CHECKERBOARD_COLOR_PRESENCE_DOWNSAMPLER_TOP_ASSERT_SVH
`define CHECKERBOARD_COLOR_PRESENCE_DOWNSAMPLER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CBCPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CBCPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CBCPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CBCPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/cbcpd_pkg.sv -----
package cbcpd_pkg;

    localparam int SCREEN_WIDTH  = 160;
    localparam int SCREEN_HEIGHT = 210;
    localparam int CELL_SIZE     = 5;
    localparam int GRID_COLS     = SCREEN_WIDTH / CELL_SIZE;
    localparam int GRID_ROWS     = SCREEN_HEIGHT / CELL_SIZE;

    localparam int NUM_CODES  = 8;
    localparam int CODE_W     = 8;
    localparam int PIX_W      = 8;
    localparam int X_W        = $clog2(SCREEN_WIDTH);
    localparam int Y_W        = $clog2(SCREEN_HEIGHT);
    localparam int OFS_W      = $clog2(CELL_SIZE);
    localparam int CC_W       = $clog2(GRID_COLS + 1);
    localparam int CR_W       = $clog2(GRID_ROWS + 1);
    localparam int AW         = $clog2(GRID_COLS);
    localparam int ROW_OUT_W  = 6;
    localparam int COL_OUT_W  = 5;
    localparam int APB_ADDR_W = $clog2(NUM_CODES) + 2;
    localparam int APB_DATA_W = 32;
    localparam int IDX_W      = $clog2(NUM_CODES);
    localparam int OFIFO_DEPTH = 2;
    localparam int OCNT_W     = $clog2(OFIFO_DEPTH + 1);
    localparam int OUT_DATA_W = 24;
    localparam int IN_DATA_W  = 8;

    typedef logic [CODE_W-1:0] t_code;
    typedef t_code [NUM_CODES-1:0] t_codes;

    localparam t_codes CODE_RESET = {8'd0, 8'd58, 8'd121, 8'd152,
                                     8'd188, 8'd217, 8'd233, 8'd255};

    typedef struct packed {
        logic [AW-1:0]        addr;
        logic                 clr;
        logic                 cnt;
        logic [CODE_W-1:0]    bits;
        logic                 last;
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic                 done;
    } t_acc_req;

    typedef struct packed {
        logic                 done;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_OUT_W-1:0] row;
        logic [CODE_W-1:0]    value;
    } t_out_item;

endpackage

// ----- rtl/core/cbcpd_cfg.sv -----
module cbcpd_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cbcpd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cbcpd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cbcpd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready,
    output cbcpd_pkg::t_codes                  o_codes
);
    import cbcpd_pkg::*;

    t_codes            r_code;
    logic [IDX_W-1:0]  idx;

    assign idx    = paddr[APB_ADDR_W-1:2];
    assign pready = 1'b1;
    assign prdata = {{(APB_DATA_W-CODE_W){1'b0}}, r_code[idx]};
    assign o_codes = r_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= CODE_RESET;
        end else if (psel && penable && pwrite && pready) begin
            r_code[idx] <= pwdata[CODE_W-1:0];
        end
    end

endmodule

// ----- rtl/core/cbcpd_acc.sv -----
`include "checkerboard_color_presence_downsampler_top_assert.svh"
module cbcpd_acc (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  cbcpd_pkg::t_acc_req   i_req,
    output logic                  o_last_pend,
    output logic                  o_push,
    output cbcpd_pkg::t_out_item  o_item
);
    import cbcpd_pkg::*;

    logic [CODE_W-1:0] r_mem [GRID_COLS];
    logic [CODE_W-1:0] r_rd;
    t_acc_req          r_s1;
    logic              r_s1_valid;
    logic              r_fwd_valid;
    logic [AW-1:0]     r_fwd_addr;
    logic [CODE_W-1:0] r_fwd_data;
    logic [CODE_W-1:0] old_val;
    logic [CODE_W-1:0] n_val;

    always_comb begin
        old_val = (r_fwd_valid && r_fwd_addr == r_s1.addr) ? r_fwd_data : r_rd;
        n_val   = (r_s1.clr ? '0 : old_val) | (r_s1.cnt ? r_s1.bits : '0);
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_req_valid) begin
            r_rd <= r_mem[i_req.addr];
            r_s1 <= i_req;
        end
    end

    // write port
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_mem[r_s1.addr] <= n_val;
            r_fwd_addr       <= r_s1.addr;
            r_fwd_data       <= n_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_req_valid;
            if (r_s1_valid) begin
                r_fwd_valid <= 1'b1;
            end
        end
    end

    assign o_last_pend  = r_s1_valid && r_s1.last;
    assign o_push       = r_s1_valid && r_s1.last;
    assign o_item.value = n_val;
    assign o_item.row   = r_s1.row;
    assign o_item.col   = r_s1.col;
    assign o_item.done  = r_s1.done;

    `CBCPD_ASSERT_NEXT(a_fwd_tracks_write, i_clk, i_rst_n, r_s1_valid, r_fwd_valid && r_fwd_addr == $past(r_s1.addr))
    `CBCPD_ASSERT_IMPLY(a_done_is_last, i_clk, i_rst_n, i_req_valid && i_req.done, i_req.last)

endmodule

// ----- rtl/core/cbcpd_ofifo.sv -----
`include "checkerboard_color_presence_downsampler_top_assert.svh"
module cbcpd_ofifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  cbcpd_pkg::t_out_item             i_item,
    input  logic                             i_pop,
    output logic                             o_valid,
    output cbcpd_pkg::t_out_item             o_item,
    output logic [cbcpd_pkg::OCNT_W-1:0]     o_cnt
);
    import cbcpd_pkg::*;

    localparam int PW = $clog2(OFIFO_DEPTH);

    t_out_item         r_buf [OFIFO_DEPTH];
    logic [PW-1:0]     r_wp;
    logic [PW-1:0]     r_rp;
    logic [OCNT_W-1:0] r_cnt;
    logic              pop;

    assign pop     = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_buf[r_rp];
    assign o_cnt   = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(OFIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(OFIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `CBCPD_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, i_push, r_cnt < OCNT_W'(OFIFO_DEPTH) || pop)

endmodule

// ----- rtl/core/checkerboard_color_presence_downsampler_top.sv -----
// A cell reaches o_m_axis_* via the accumulator's request register and the result buffer.
// Throughput: one pixel per cycle while not stalled; the accumulator RAM is read and
// written back per pixel, forwarding the last write to the next pixel of the same cell.
// Input stalls while the result buffer holds two cells, or one with another being written.
// Reset (i_rst_n low, synchronous): position (0,0), color codes to defaults,
// buffer empty; accumulator entries are cleared at each cell's first pixel.
`include "checkerboard_color_presence_downsampler_top_assert.svh"
module checkerboard_color_presence_downsampler_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [cbcpd_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,  // [7:0] pixel
    input  logic                                 i_s_axis_tuser,  // [0] frame_start
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // [7:0] cell_value, [13:8] cell_row, [18:14] cell_col, [23:19] zero
    output logic [cbcpd_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    output logic                                 o_m_axis_tlast,  // frame_done
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [cbcpd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cbcpd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cbcpd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);
    import cbcpd_pkg::*;

    t_codes            codes;
    logic              accept;
    logic [X_W-1:0]    r_x,  c_x,  n_x;
    logic [Y_W-1:0]    r_y,  c_y,  n_y;
    logic [OFS_W-1:0]  r_ox, c_ox, n_ox;
    logic [OFS_W-1:0]  r_oy, c_oy, n_oy;
    logic [CC_W-1:0]   r_cc, c_cc, n_cc;
    logic [CR_W-1:0]   r_cr, c_cr, n_cr;
    logic              in_grid;
    logic              req_valid;
    t_acc_req          req;
    logic              last_pend;
    logic              push;
    t_out_item         push_item;
    t_out_item         out_item;
    logic [OCNT_W-1:0] ocnt;

    cbcpd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_codes (codes)
    );

    assign o_s_axis_tready = (ocnt == '0) || (ocnt == OCNT_W'(1) && !last_pend);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        if (i_s_axis_tuser) begin
            c_x = '0; c_y = '0; c_ox = '0; c_oy = '0; c_cc = '0; c_cr = '0;
        end else begin
            c_x = r_x; c_y = r_y; c_ox = r_ox; c_oy = r_oy; c_cc = r_cc; c_cr = r_cr;
        end

        n_x = c_x; n_y = c_y; n_ox = c_ox; n_oy = c_oy; n_cc = c_cc; n_cr = c_cr;
        if (c_x == X_W'(SCREEN_WIDTH - 1)) begin
            n_x  = '0;
            n_ox = '0;
            n_cc = '0;
            if (c_y == Y_W'(SCREEN_HEIGHT - 1)) begin
                n_y  = '0;
                n_oy = '0;
                n_cr = '0;
            end else begin
                n_y = c_y + 1'b1;
                if (c_oy == OFS_W'(CELL_SIZE - 1)) begin
                    n_oy = '0;
                    n_cr = c_cr + 1'b1;
                end else begin
                    n_oy = c_oy + 1'b1;
                end
            end
        end else begin
            n_x = c_x + 1'b1;
            if (c_ox == OFS_W'(CELL_SIZE - 1)) begin
                n_ox = '0;
                n_cc = c_cc + 1'b1;
            end else begin
                n_ox = c_ox + 1'b1;
            end
        end

        in_grid = (c_cc < CC_W'(GRID_COLS)) && (c_cr < CR_W'(GRID_ROWS));

        for (int i = 0; i < NUM_CODES; i++) begin
            req.bits[NUM_CODES-1-i] = (codes[i] == i_s_axis_tdata[PIX_W-1:0]);
        end
        req.addr = c_cc[AW-1:0];
        req.clr  = (c_ox == '0) && (c_oy == '0);
        req.cnt  = c_ox[0] ^ c_y[0] ^ c_cc[0];
        req.last = (c_ox == OFS_W'(CELL_SIZE - 1)) && (c_oy == OFS_W'(CELL_SIZE - 1));
        req.row  = ROW_OUT_W'(c_cr);
        req.col  = COL_OUT_W'(c_cc);
        req.done = (c_cr == CR_W'(GRID_ROWS - 1)) && (c_cc == CC_W'(GRID_COLS - 1))
                   && req.last;
    end

    assign req_valid = accept && in_grid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x  <= '0;
            r_y  <= '0;
            r_ox <= '0;
            r_oy <= '0;
            r_cc <= '0;
            r_cr <= '0;
        end else if (accept) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_ox <= n_ox;
            r_oy <= n_oy;
            r_cc <= n_cc;
            r_cr <= n_cr;
        end
    end

    cbcpd_acc u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_last_pend (last_pend),
        .o_push      (push),
        .o_item      (push_item)
    );

    cbcpd_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_item  (out_item),
        .o_cnt   (ocnt)
    );

    assign o_m_axis_tdata = {{(OUT_DATA_W-CODE_W-ROW_OUT_W-COL_OUT_W){1'b0}},
                             out_item.col, out_item.row, out_item.value};
    assign o_m_axis_tlast = out_item.done;

    `CBCPD_ASSERT_IMPLY(a_stall_has_result, i_clk, i_rst_n, !o_s_axis_tready, o_m_axis_tvalid)

endmodule

// ----- bench/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbcpd_pkg::*;

    localparam int REG_STRIDE   = 4;
    localparam int DRAIN_CYCLES = 10;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_AT      = 4;
    localparam int HOLD_CYCLES  = 600;
    localparam int ROW_PIXELS   = SCREEN_WIDTH * CELL_SIZE;
    localparam int TAIL_PIXELS  = 100;

    typedef enum int {
        REG_CODE_7, REG_CODE_6, REG_CODE_5, REG_CODE_4,
        REG_CODE_3, REG_CODE_2, REG_CODE_1, REG_CODE_0
    } t_reg_idx;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             start;
    } t_pixel_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    logic [IN_DATA_W-1:0] i_s_axis_tdata = '0;   // [7:0] pixel
    logic i_s_axis_tuser = 1'b0;                 // [0] frame_start
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;       // [7:0] value, [13:8] row, [18:14] col
    logic o_m_axis_tlast;                        // frame_done
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    checkerboard_color_presence_downsampler_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    t_code       code_q [NUM_CODES];
    logic [7:0]  cell_acc [GRID_COLS];
    int          pos_col;
    int          pos_row;

    t_pixel_beat pend_q [$];
    t_out_item   cell_exp_q [$];

    logic in_taken  = 1'b0;
    logic out_taken = 1'b0;
    int   n_out     = 0;
    int   err_cnt   = 0;
    int   idle_cnt  = 0;
    int   tx_gap    = 0;
    int   rx_gap    = 0;
    bit   tx_burst  = 1'b0;
    bit   rx_burst  = 1'b0;
    bit   held      = 1'b0;

    function automatic bit cell_step(input logic [PIX_W-1:0] pix, input logic start,
                                     output t_out_item res);
        int x, y, cc, cr, ox, oy;
        logic [7:0] hits;
        bit got;
        got = 1'b0;
        res = '0;
        if (start) begin
            pos_col = 0;
            pos_row = 0;
        end
        x = pos_col;
        y = pos_row;
        cc = x / CELL_SIZE;
        cr = y / CELL_SIZE;
        ox = x % CELL_SIZE;
        oy = y % CELL_SIZE;
        if (cc < GRID_COLS && cr < GRID_ROWS) begin
            if (oy == 0 && ox == 0)
                cell_acc[cc] = '0;
            if (((ox + y + cc) % 2) != 0) begin
                hits = '0;
                for (int i = 0; i < NUM_CODES; i++)
                    if (code_q[i] == pix)
                        hits[NUM_CODES-1-i] = 1'b1;
                cell_acc[cc] = cell_acc[cc] | hits;
            end
            if (oy == CELL_SIZE - 1 && ox == CELL_SIZE - 1) begin
                res.value = cell_acc[cc];
                res.row   = cr[ROW_OUT_W-1:0];
                res.col   = cc[COL_OUT_W-1:0];
                res.done  = (cr == GRID_ROWS - 1 && cc == GRID_COLS - 1);
                got = 1'b1;
            end
        end
        if (x + 1 >= SCREEN_WIDTH) begin
            pos_col = 0;
            pos_row = (y + 1 >= SCREEN_HEIGHT) ? 0 : y + 1;
        end else begin
            pos_col = x + 1;
        end
        return got;
    endfunction

    function automatic int draw_tx_gap();
        if ($urandom_range(0, 99) == 0)
            tx_burst = !tx_burst;
        return tx_burst ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic int draw_rx_gap();
        if ($urandom_range(0, 29) == 0)
            rx_burst = !rx_burst;
        return rx_burst ? 0 : $urandom_range(0, 17);
    endfunction

    // sampling: predictor, result check, watchdog
    always @(posedge i_clk) begin
        t_out_item r;
        t_out_item e;
        logic [OUT_DATA_W-1:0] e_data;
        if (i_rst_n) begin
            in_taken  <= i_s_axis_tvalid && o_s_axis_tready;
            out_taken <= o_m_axis_tvalid && i_m_axis_tready;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                n_out <= n_out + 1;
                if (cell_exp_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: unexpected result tdata=%h tlast=%b",
                                 $realtime, o_m_axis_tdata, o_m_axis_tlast);
                end else begin
                    e = cell_exp_q.pop_front();
                    e_data = {{(OUT_DATA_W-19){1'b0}}, e.col, e.row, e.value};
                    if (o_m_axis_tdata[7:0] !== e.value ||
                        o_m_axis_tdata[13:8] !== e.row ||
                        o_m_axis_tdata[18:14] !== e.col ||
                        o_m_axis_tdata[OUT_DATA_W-1:19] !== '0 ||
                        o_m_axis_tlast !== e.done) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("%0t: cell mismatch exp tdata=%h tlast=%b got tdata=%h tlast=%b",
                                     $realtime, e_data, e.done, o_m_axis_tdata, o_m_axis_tlast);
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                if (cell_step(i_s_axis_tdata[PIX_W-1:0], i_s_axis_tuser, r))
                    cell_exp_q.push_back(r);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
                (psel && penable))
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= STALL_LIMIT) begin
                $display("%0t: no progress", $realtime);
                $display("** checkerboard_color_presence_downsampler_top: FAILED **");
                $finish;
            end
        end
    end

    // pixel driver
    always @(negedge i_clk) begin
        t_pixel_beat b;
        if (i_rst_n) begin
            if (!(i_s_axis_tvalid && !in_taken)) begin
                if (i_s_axis_tvalid)
                    tx_gap = draw_tx_gap();
                if (tx_gap == 0 && pend_q.size() != 0) begin
                    b = pend_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= b.pix;
                    i_s_axis_tuser  <= b.start;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                    if (tx_gap > 0)
                        tx_gap--;
                end
            end
        end
    end

    // result receiver; one long hold-off while cells are dense
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_taken) begin
                rx_gap = draw_rx_gap();
                if (n_out == HOLD_AT && !held) begin
                    rx_gap = HOLD_CYCLES;
                    held = 1'b1;
                end
            end
            if (rx_gap > 0) begin
                i_m_axis_tready <= 1'b0;
                rx_gap--;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic reg_write(input t_reg_idx idx, input t_code val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(int'(idx) * REG_STRIDE);
        pwdata  <= APB_DATA_W'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        code_q[idx] = val;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic queue_beat(input logic [PIX_W-1:0] pix, input logic start);
        t_pixel_beat b;
        b.pix = pix;
        b.start = start;
        pend_q.push_back(b);
    endtask

    // mostly random gray, with a per-line share of exact code hits
    task automatic queue_pixels(input int n, input bit mark_first, input int noise);
        int density;
        logic [PIX_W-1:0] pix;
        density = 0;
        for (int k = 0; k < n; k++) begin
            if (k % SCREEN_WIDTH == 0)
                density = $urandom_range(0, 30);
            if ($urandom_range(0, 99) < density)
                pix = code_q[$urandom_range(0, NUM_CODES - 1)];
            else
                pix = $urandom_range(0, 255);
            queue_beat(pix, (k == 0 && mark_first) ||
                            (noise != 0 && $urandom_range(0, noise - 1) == 0));
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pend_q.size() != 0 || i_s_axis_tvalid || cell_exp_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_code pool [3];
        for (int i = 0; i < NUM_CODES; i++)
            code_q[i] = CODE_RESET[i];
        for (int i = 0; i < GRID_COLS; i++)
            cell_acc[i] = '0;
        pos_col = 0;
        pos_row = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset codes: directed extremes, restarts mid-line, then most of a cell row
        queue_beat(8'd255, 1'b1);
        queue_beat(8'd0, 1'b0);
        queue_beat(8'd233, 1'b0);
        queue_beat(8'd217, 1'b0);
        queue_beat(8'd188, 1'b0);
        queue_beat(8'd152, 1'b0);
        queue_beat(8'd121, 1'b0);
        queue_beat(8'd58, 1'b0);
        queue_beat(8'd1, 1'b0);
        queue_beat(8'd254, 1'b0);
        queue_beat(8'h55, 1'b0);
        queue_beat(8'hAA, 1'b0);
        queue_beat(8'h80, 1'b0);
        queue_beat(8'h7F, 1'b0);
        queue_beat(8'd0, 1'b1);
        queue_beat(8'd255, 1'b0);
        queue_beat(8'd255, 1'b1);
        queue_beat(8'd58, 1'b1);
        queue_pixels(ROW_PIXELS - TAIL_PIXELS, 1'b1, 0);
        wait_idle();

        // codes from a small pool with both extremes, so several are equal;
        // changed mid-cell, then the cell row is finished
        pool[0] = 8'd0;
        pool[1] = 8'd255;
        pool[2] = $urandom_range(0, 255);
        for (int i = 0; i < NUM_CODES; i++)
            reg_write(t_reg_idx'(i), pool[$urandom_range(0, 2)]);
        queue_pixels(TAIL_PIXELS, 1'b0, 0);
        wait_idle();

        if (err_cnt == 0)
            $display("** checkerboard_color_presence_downsampler_top: PASSED **");
        else
            $display("** checkerboard_color_presence_downsampler_top: FAILED **");
        $finish;
    end

endmodule
